FILE: hw/rtl/pidff_pkg.sv
// Package for the PID controller with deadband and feed-forward.
// Holds register indexes, sequencer states and fixed widths; no dependencies.
package pidff_pkg;
  localparam int unsigned GainW = 32;
  localparam int unsigned SumW = 64;
  localparam int unsigned IntegralLimit = 0;
  localparam logic [14:0] DefaultDeadband = 15'd4;

  typedef enum logic [2:0] {
    REG_KP   = 3'd0,
    REG_KI   = 3'd1,
    REG_KD   = 3'd2,
    REG_KVFF = 3'd3,
    REG_KAFF = 3'd4,
    REG_EN   = 3'd5,
    REG_DB   = 3'd6,
    REG_LIM  = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P,
    ST_D,
    ST_VFF,
    ST_ACC,
    ST_DIV,
    ST_DIVFIX,
    ST_ICUR,
    ST_IPOT,
    ST_GROW,
    ST_IFIN,
    ST_OUT
  } state_t;
endpackage

FILE: hw/rtl/pid_deadband_feedforward.sv
// PID controller with deadband, term enables, feed-forward and anti-windup.
// Each input word runs through set-up (P, D, VFF, ACC), the divide and the finish
// states (DIVFIX to OUT); the divide is cut short when the acceleration division is
// skipped. No new word is taken until back in idle. A result left waiting holds the
// sequencer in its last state. Shared multiplier, radix-2 restoring divider.
// Reset (rst_n synchronous low): registers to defaults, state cleared, idle.
module pid_deadband_feedforward (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_setpoint,
  input  logic signed [15:0] in_measured,
  input  logic        [15:0] in_step_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_drive,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic        [2:0]  cfg_index,
  input  logic        [31:0] cfg_data
);
  localparam int unsigned W = pidff_pkg::SumW;

  logic signed [31:0] kp_r, ki_r, kd_r, kv_r, ka_r;
  logic [4:0]  en_r;
  logic [14:0] db_r, lim_r;
  logic signed [31:0] esum_r, esum_nxt;
  logic signed [16:0] perr_r;
  logic signed [15:0] psp_r;

  pidff_pkg::state_t st_r, st_nxt;
  logic signed [15:0] sp_r;
  logic [15:0] step_r;
  logic signed [16:0] err_r;
  logic in_db_r;
  logic signed [W-1:0] base_r, icur_r, acc_r;
  logic num_neg_r;
  logic [W-1:0] quo_r;
  logic [16:0] rem_r;
  logic [5:0] cnt_r;
  logic signed [15:0] drive_r;
  logic sat_r, out_valid_r;
  logic out_load;

  logic signed [32:0] ma, mb;
  logic signed [W-1:0] prod;
  pidff_mul u_mul (.clk(clk), .a(ma), .b(mb), .prod_r(prod));

  logic signed [16:0] err_raw, err_mag;
  logic [14:0] db_eff;
  logic signed [W-1:0] lim64;
  logic signed [32:0] esum_plus;
  logic signed [31:0] imax;
  logic [17:0] rem_sh;
  logic [16:0] rem_sub;

  assign err_raw = 17'(in_setpoint) - 17'(in_measured);
  assign err_mag = err_raw[16] ? -err_raw : err_raw;
  assign db_eff  = (db_r == '0) ? pidff_pkg::DefaultDeadband : db_r;
  assign lim64   = W'($signed({1'b0, lim_r})) <<< 16;
  assign esum_plus = 33'(esum_r) + 33'(err_r);
  assign imax    = (pidff_pkg::IntegralLimit > 0) ? 32'(pidff_pkg::IntegralLimit)
                                                  : 32'({lim_r, 1'b0});
  assign rem_sh  = {rem_r, quo_r[W-1]};
  assign rem_sub = rem_sh[16:0] - 17'(step_r);
  assign out_load = (st_r == pidff_pkg::ST_OUT) && (!out_valid_r || out_ready);

  function automatic logic beyond(input logic signed [W-1:0] x,
                                  input logic signed [W-1:0] l);
    beyond = (x > l) || (x < -l);
  endfunction

  always_comb begin
    ma = '0;
    mb = '0;
    case (st_r)
      pidff_pkg::ST_P: begin
        ma = 33'(kp_r);
        mb = 33'(err_r);
      end
      pidff_pkg::ST_D: begin
        ma = 33'(kd_r);
        mb = 33'(err_r) - 33'(perr_r);
      end
      pidff_pkg::ST_VFF: begin
        ma = 33'(kv_r);
        mb = 33'(sp_r);
      end
      pidff_pkg::ST_ACC: begin
        ma = 33'(ka_r);
        mb = 33'(sp_r) - 33'(psp_r);
      end
      pidff_pkg::ST_ICUR: begin
        ma = 33'(ki_r);
        mb = 33'(esum_r);
      end
      pidff_pkg::ST_IPOT: begin
        ma = 33'(ki_r);
        mb = esum_plus;
      end
      pidff_pkg::ST_IFIN, pidff_pkg::ST_OUT: begin
        ma = 33'(ki_r);
        mb = 33'(esum_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  logic signed [W-1:0] cur, pot, fin;
  logic grow;
  assign cur = base_r + (en_r[1] ? icur_r : '0);
  assign pot = base_r + (en_r[1] ? prod : '0);
  always_comb begin
    if (!beyond(cur, lim64)) begin
      grow = !beyond(pot, lim64) || (pot > lim64 && err_r < 0) ||
             (pot < -lim64 && err_r > 0);
    end else begin
      grow = (cur > lim64 && err_r < 0) || (cur < -lim64 && err_r > 0);
    end
  end
  assign fin = base_r + (en_r[1] ? prod : '0);

  always_comb begin
    esum_nxt = esum_r;
    if (st_r == pidff_pkg::ST_GROW) begin
      if (en_r[1] && grow) esum_nxt = esum_plus[31:0];
      if (esum_nxt > imax) esum_nxt = imax;
      else if (esum_nxt < -imax) esum_nxt = -imax;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      pidff_pkg::ST_IDLE:   if (in_valid) st_nxt = pidff_pkg::ST_P;
      pidff_pkg::ST_P:      st_nxt = pidff_pkg::ST_D;
      pidff_pkg::ST_D:      st_nxt = pidff_pkg::ST_VFF;
      pidff_pkg::ST_VFF:    st_nxt = pidff_pkg::ST_ACC;
      pidff_pkg::ST_ACC:    st_nxt = pidff_pkg::ST_DIV;
      pidff_pkg::ST_DIV:    if (cnt_r == '1 || !en_r[4] || step_r == '0)
                              st_nxt = pidff_pkg::ST_DIVFIX;
      pidff_pkg::ST_DIVFIX: st_nxt = pidff_pkg::ST_ICUR;
      pidff_pkg::ST_ICUR:   st_nxt = pidff_pkg::ST_IPOT;
      pidff_pkg::ST_IPOT:   st_nxt = pidff_pkg::ST_GROW;
      pidff_pkg::ST_GROW:   st_nxt = pidff_pkg::ST_IFIN;
      pidff_pkg::ST_IFIN:   st_nxt = pidff_pkg::ST_OUT;
      pidff_pkg::ST_OUT:    if (!out_valid_r || out_ready) st_nxt = pidff_pkg::ST_IDLE;
      default:              st_nxt = pidff_pkg::ST_IDLE;
    endcase
  end

  assign in_ready = (st_r == pidff_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_drive = drive_r;
  assign out_saturated = sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= pidff_pkg::ST_IDLE;
      kp_r <= '0; ki_r <= '0; kd_r <= '0; kv_r <= '0; ka_r <= '0;
      en_r <= 5'h1f;
      db_r <= 15'd4;
      lim_r <= 15'd16384;
      esum_r <= '0;
      perr_r <= '0;
      psp_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      esum_r <= esum_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pidff_pkg::REG_KP:   kp_r <= cfg_data;
          pidff_pkg::REG_KI:   ki_r <= cfg_data;
          pidff_pkg::REG_KD:   kd_r <= cfg_data;
          pidff_pkg::REG_KVFF: kv_r <= cfg_data;
          pidff_pkg::REG_KAFF: ka_r <= cfg_data;
          pidff_pkg::REG_EN:   en_r <= cfg_data[4:0];
          pidff_pkg::REG_DB:   db_r <= cfg_data[14:0];
          pidff_pkg::REG_LIM:  lim_r <= cfg_data[14:0];
          default: ;
        endcase
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (st_r == pidff_pkg::ST_IDLE && in_valid) begin
        sp_r    <= in_setpoint;
        step_r  <= in_step_us;
        in_db_r <= err_mag < 17'(db_eff);
        err_r   <= (err_mag < 17'(db_eff)) ? '0 : err_raw;
      end
      case (st_r)
        pidff_pkg::ST_D: base_r <= en_r[0] ? prod : '0;
        pidff_pkg::ST_VFF: if (en_r[2] && !in_db_r) base_r <= base_r + prod;
        pidff_pkg::ST_ACC: begin
          if (en_r[3]) base_r <= base_r + prod;
          psp_r <= sp_r;
          cnt_r <= '0;
          rem_r <= '0;
          acc_r <= '0;
        end
        pidff_pkg::ST_DIV: begin
          if (cnt_r == '0) begin
            num_neg_r <= prod[W-1];
            quo_r <= prod[W-1] ? W'(-prod) : W'(prod);
            cnt_r <= cnt_r + 6'd1;
          end else begin
            if (rem_sh >= {2'b0, step_r}) begin
              rem_r <= rem_sub;
              quo_r <= {quo_r[W-2:0], 1'b1};
            end else begin
              rem_r <= rem_sh[16:0];
              quo_r <= {quo_r[W-2:0], 1'b0};
            end
            cnt_r <= cnt_r + 6'd1;
          end
        end
        pidff_pkg::ST_DIVFIX: begin
          if (en_r[4] && step_r != '0) begin
            // last quotient bit
            logic [W-1:0] q;
            q = (rem_sh >= {2'b0, step_r}) ? {quo_r[W-2:0], 1'b1}
                                           : {quo_r[W-2:0], 1'b0};
            acc_r <= num_neg_r ? -$signed(q) : $signed(q);
          end
        end
        pidff_pkg::ST_ICUR: base_r <= base_r + acc_r;
        pidff_pkg::ST_IPOT: icur_r <= prod;
        pidff_pkg::ST_OUT: begin
          if (out_load) begin
            if (fin > lim64) begin
              drive_r <= 16'(lim_r);
              sat_r <= 1'b1;
            end else if (fin < -lim64) begin
              drive_r <= -16'(lim_r);
              sat_r <= 1'b1;
            end else begin
              drive_r <= fin[W-1] ? -16'(W'(-fin) >> 16) : 16'(fin >>> 16);
              sat_r <= 1'b0;
            end
            if (!in_db_r) perr_r <= err_r;
          end
        end
        default: ;
      endcase
    end
  end
endmodule

FILE: hw/rtl/pidff_mul.sv
// Shared signed 33 x 33 multiplier with registered product.
// Depends on pidff_pkg.
module pidff_mul (
  input  logic                          clk,
  input  logic signed [32:0]            a,
  input  logic signed [32:0]            b,
  output logic signed [pidff_pkg::SumW-1:0] prod_r
);
  logic signed [65:0] full;
  assign full = a * b;
  always_ff @(posedge clk) begin
    prod_r <= full[pidff_pkg::SumW-1:0];
  end
endmodule

FILE: hw/rtl/pid_deadband_feedforward_chk.sv
// Port checker for the PID controller; bound to the top level.
// Depends on pid_deadband_feedforward.
module pid_deadband_feedforward_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_drive,
  input logic               out_saturated
);
  a_rst_clear: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid) else $error("result right after reset");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive))
    else $error("output dropped");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_saturated |-> out_drive != -16'sd32768)
    else $error("bad drive");
endmodule

bind pid_deadband_feedforward pid_deadband_feedforward_chk u_chk (.*);
